### design/postfix_expression_evaluator_macros.svh
// Assertion macros of the postfix expression evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rpn_pkg.sv
// Types and constants of the postfix expression evaluator.
package rpn_pkg;

  localparam int VAL_W  = 48;
  localparam int HALF_W = VAL_W / 2;
  localparam int ACC_W  = 31;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [6:0] CENT     = 7'd100;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIV_ZERO  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_DIV, S_FIN, S_RES
  } state_e;

  typedef enum logic [1:0] {
    K_SIMPLE, K_POW, K_BIN
  } kind_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQR
  } op_e;

  typedef struct packed {
    logic char_en;
    logic exec_bin;
    logic arith_step;
    logic arith_wr;
    logic push_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  last_in;
    logic  last_q;
    op_e   op;
    logic  arith_done;
    logic  out_free;
  } stat_t;

endpackage

### design/rpn_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_expr;

  modport source (output valid, output char_code, output end_of_expr, input ready);
  modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface rpn_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [47:0]       value;
  logic                     is_whole;
  rpn_pkg::status_e         status;

  modport source (output valid, output value, output is_whole, output status, input ready);
  modport sink   (input valid, input value, input is_whole, input status, output ready);
endinterface

### design/rpn_ctrl.sv
// Sequencer of the evaluator: steps each character through read, arithmetic and result.
module rpn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpn_pkg::stat_t stat_i,
  output rpn_pkg::cmd_t  cmd_o
);
  import rpn_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.kind)
            K_POW:   state_d = S_MUL;
            K_BIN:   state_d = S_RD;
            default: state_d = stat_i.last_in ? S_FIN : S_IDLE;
          endcase
        end
      end
      S_RD: begin
        case (stat_i.op)
          OP_MUL:  state_d = S_MUL;
          OP_DIV:  state_d = S_DIV;
          default: state_d = stat_i.last_q ? S_FIN : S_IDLE;
        endcase
      end
      S_MUL, S_DIV: begin
        if (stat_i.arith_done) state_d = stat_i.last_q ? S_FIN : S_IDLE;
      end
      S_FIN: state_d = S_RES;
      S_RES: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.char_en = in_valid_i;
      end
      S_RD: cmd_o.exec_bin = 1'b1;
      S_MUL, S_DIV: begin
        cmd_o.arith_wr   = stat_i.arith_done;
        cmd_o.arith_step = !stat_i.arith_done;
      end
      S_FIN: cmd_o.push_fin = 1'b1;
      S_RES: cmd_o.emit = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/rpn_dp.sv
// Datapath: token parser, value stack, multiply and divide units, result register.
module rpn_dp #(
  parameter int DEPTH = 64,
  parameter int FRAC  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [7:0]               char_code_i,
  input  logic                     end_of_expr_i,
  input  logic                     out_ready_i,
  input  rpn_pkg::cmd_t            cmd_i,
  output rpn_pkg::stat_t           stat_o,
  output logic                     out_valid_o,
  output logic signed [47:0]       value_o,
  output logic                     is_whole_o,
  output rpn_pkg::status_e         status_o
);
  import rpn_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = VAL_W + FRAC;
  localparam int KW = $clog2(DW + 1);
  localparam int PW = 2 * VAL_W;

  function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  function automatic logic [VAL_W-1:0] sat_mag(input logic [PW-1:0] m, input logic neg);
    logic over;
    over = |m[PW-1:VAL_W-1];
    if (over) return neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    return neg ? (~m[VAL_W-1:0] + VAL_W'(1)) : m[VAL_W-1:0];
  endfunction

  logic [CW-1:0]    cnt_q;
  logic [VAL_W-1:0] tos_q;
  logic [ACC_W-1:0] acc_q;
  logic             tok_q, de_q, last_q, neg_q, out_valid_q;
  status_e          err_q;
  op_e              op_q;
  logic [VAL_W-1:0] ma_q, mb_q, rem_q, rd_q;
  logic [PW-1:0]    prod_q;
  logic [DW-1:0]    quot_q;
  logic [KW-1:0]    k_q;
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] val_q;
  logic             whole_q;
  status_e          st_q;

  // Character decode
  logic       is_digit, is_binop, ok, tos_zero;
  logic [3:0] dval;
  op_e        bin_op;
  kind_e      kind;
  logic [7:0] dsub;

  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign dsub     = char_code_i - CH_ZERO;
  assign dval     = dsub[3:0];
  assign ok       = (err_q == ST_OK);
  assign tos_zero = (tos_q == '0);
  assign is_binop = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS) ||
                    (char_code_i == CH_MUL) || (char_code_i == CH_DIV);

  always_comb begin
    case (char_code_i)
      CH_PLUS:  bin_op = OP_ADD;
      CH_MINUS: bin_op = OP_SUB;
      CH_MUL:   bin_op = OP_MUL;
      default:  bin_op = OP_DIV;
    endcase
  end

  always_comb begin
    kind = K_SIMPLE;
    if (ok && !tok_q && !is_digit) begin
      if (char_code_i == CH_POW && cnt_q != '0) kind = K_POW;
      else if (is_binop && cnt_q > CW'(1) && !(char_code_i == CH_DIV && tos_zero)) kind = K_BIN;
    end
  end

  // Number accumulation with saturation
  logic [ACC_W+3:0] acc_n;
  logic [ACC_W-1:0] acc_next;
  assign acc_n    = ((ACC_W+4)'(acc_q) << 3) + ((ACC_W+4)'(acc_q) << 1) + (ACC_W+4)'(dval);
  assign acc_next = (acc_n > (ACC_W+4)'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : acc_n[ACC_W-1:0];

  logic [VAL_W-1:0] num_val;
  assign num_val = sat_mag(PW'(acc_q) << FRAC, 1'b0);

  // Push of a finished token
  logic do_push, push_ok, wr_en;
  assign do_push = ok && tok_q &&
                   ((cmd_i.char_en && char_code_i == CH_COMMA) || cmd_i.push_fin);
  assign push_ok = do_push && (cnt_q != CW'(DEPTH));
  assign wr_en   = push_ok && (cnt_q != '0);

  // Binary operands
  logic [VAL_W-1:0] mag_a, mag_b, mag_t;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] sum_sat;
  assign mag_a = mag(rd_q);
  assign mag_b = mag(tos_q);
  assign mag_t = mag(tos_q);
  assign sum   = (op_q == OP_SUB) ? ({rd_q[VAL_W-1], rd_q} - {tos_q[VAL_W-1], tos_q})
                                  : ({rd_q[VAL_W-1], rd_q} + {tos_q[VAL_W-1], tos_q});
  always_comb begin
    if (sum[VAL_W] != sum[VAL_W-1])
      sum_sat = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    else
      sum_sat = sum[VAL_W-1:0];
  end

  // Multiply partial product and divide step
  logic [HALF_W-1:0] pa, pb;
  logic [VAL_W-1:0]  pp;
  logic [PW-1:0]     pp_sh;
  logic [VAL_W:0]    r2;
  logic              ge;
  logic [VAL_W:0]    rdiff;
  assign pa = k_q[1] ? ma_q[VAL_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign pb = k_q[0] ? mb_q[VAL_W-1:HALF_W] : mb_q[HALF_W-1:0];
  assign pp = pa * pb;
  always_comb begin
    case ({1'b0, k_q[1]} + {1'b0, k_q[0]})
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << HALF_W;
      default: pp_sh = PW'(pp) << VAL_W;
    endcase
  end
  assign r2    = {rem_q, quot_q[DW-1]};
  assign ge    = r2 >= {1'b0, mb_q};
  assign rdiff = r2 - {1'b0, mb_q};

  logic [VAL_W-1:0] ar_res;
  assign ar_res = (op_q == OP_DIV) ? sat_mag(PW'(quot_q), neg_q) : sat_mag(prod_q >> FRAC, neg_q);

  // Final result
  status_e            st_fin;
  logic [FRAC+6:0]    f100;
  assign f100 = (FRAC+7)'(mag_t[FRAC-1:0]) * (FRAC+7)'(CENT);
  always_comb begin
    if (!ok)               st_fin = err_q;
    else if (cnt_q == '0)  st_fin = ST_EMPTY;
    else                   st_fin = ST_OK;
  end

  // Stack memory: write the old top on push, read the entry below the top
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(cnt_q - CW'(1))] <= tos_q;
    rd_q <= mem[AW'(cnt_q - CW'(2))];
  end

  // Arithmetic unit registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.char_en && kind == K_POW) begin
      ma_q   <= mag_t;
      mb_q   <= mag_t;
      neg_q  <= 1'b0;
      prod_q <= '0;
    end else if (cmd_i.exec_bin) begin
      ma_q   <= mag_a;
      mb_q   <= mag_b;
      neg_q  <= rd_q[VAL_W-1] ^ tos_q[VAL_W-1];
      prod_q <= '0;
      quot_q <= {mag_a, {FRAC{1'b0}}};
      rem_q  <= '0;
    end else if (cmd_i.arith_step) begin
      if (op_q == OP_DIV) begin
        rem_q  <= ge ? rdiff[VAL_W-1:0] : r2[VAL_W-1:0];
        quot_q <= {quot_q[DW-2:0], ge};
      end else begin
        prod_q <= prod_q + pp_sh;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      val_q   <= (st_fin == ST_OK) ? tos_q : '0;
      whole_q <= (st_fin == ST_OK) && (f100[FRAC+6:FRAC] == '0);
      st_q    <= st_fin;
    end
  end

  // Control and stack state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tos_q       <= '0;
      acc_q       <= '0;
      tok_q       <= 1'b0;
      de_q        <= 1'b0;
      last_q      <= 1'b0;
      err_q       <= ST_OK;
      op_q        <= OP_ADD;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_push) begin
        tok_q <= 1'b0;
        if (push_ok) begin
          tos_q <= num_val;
          cnt_q <= cnt_q + CW'(1);
        end else begin
          err_q <= ST_OVERFLOW;
        end
      end

      if (cmd_i.char_en) begin
        last_q <= end_of_expr_i;
        if (ok) begin
          if (tok_q) begin
            if (char_code_i != CH_COMMA) begin
              if (is_digit && !de_q) acc_q <= acc_next;
              else de_q <= 1'b1;
            end
          end else if (is_digit) begin
            tok_q <= 1'b1;
            de_q  <= 1'b0;
            acc_q <= ACC_W'(dval);
          end else if (kind == K_POW) begin
            op_q <= OP_SQR;
            k_q  <= '0;
          end else if (kind == K_BIN) begin
            op_q <= bin_op;
            k_q  <= '0;
          end else if (char_code_i == CH_POW || is_binop) begin
            if (char_code_i == CH_POW || cnt_q < CW'(2)) err_q <= ST_UNDERFLOW;
            else err_q <= ST_DIV_ZERO;
          end
        end
      end

      if (cmd_i.exec_bin && (op_q == OP_ADD || op_q == OP_SUB)) begin
        tos_q <= sum_sat;
        cnt_q <= cnt_q - CW'(1);
      end

      if (cmd_i.arith_step) k_q <= k_q + KW'(1);

      if (cmd_i.arith_wr) begin
        tos_q <= ar_res;
        if (op_q != OP_SQR) cnt_q <= cnt_q - CW'(1);
      end

      // Deliver the result and clear for the next expression
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        acc_q       <= '0;
        tok_q       <= 1'b0;
        de_q        <= 1'b0;
        err_q       <= ST_OK;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.kind       = kind;
  assign stat_o.last_in    = end_of_expr_i;
  assign stat_o.last_q     = last_q;
  assign stat_o.op         = op_q;
  assign stat_o.arith_done = (op_q == OP_DIV) ? (k_q == KW'(DW)) : (k_q == KW'(4));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = val_q;
  assign is_whole_o  = whole_q;
  assign status_o    = st_q;

endmodule

### design/postfix_expression_evaluator.sv
// Postfix expression evaluator top level: sequencer, datapath and checks.
//
// Characters of a comma-separated postfix expression enter on in_i, one per
// transaction; end_of_expr marks the final character. One result leaves on
// out_o for each expression: the top of stack in signed fixed point with
// FRAC_BITS fraction bits, a flag for a fraction below 0.01, and a status.
// Digits, commas, ignored characters and + or - are taken in the idle
// state; + and - then pass through the stack read state.
// A square runs four 24x24 partial products and a write-back; a multiply
// adds the stack read before them; a divide has a stack read, one
// quotient bit per cycle, and a write-back.
// The last character then passes through a final push and a result load,
// and the result transaction is offered from the output register.
// A result waiting in the output register does not block new characters;
// only the next result waits until the receiver takes the current one.
// Reset empties the stack and clears parser state and the output valid flag;
// the stack memory and the result payload registers are not cleared.
`include "postfix_expression_evaluator_macros.svh"
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpn_in_if.sink      in_i,
  rpn_out_if.source   out_o
);
  import rpn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rpn_dp #(
    .DEPTH (STACK_DEPTH),
    .FRAC  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (in_i.char_code),
    .end_of_expr_i (in_i.end_of_expr),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_o.valid),
    .value_o       (out_o.value),
    .is_whole_o    (out_o.is_whole),
    .status_o      (out_o.status)
  );

  // Error results carry a zero value and no whole flag
  `RPN_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_o.valid && (out_o.status != ST_OK), (out_o.value == '0) && !out_o.is_whole, "error result with nonzero payload")
  // Loading a result always presents it in the next cycle
  `RPN_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, cmd.emit, out_o.valid, "result load not shown on output")
  // A result is loaded only when the output register is free
  `RPN_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit, !out_o.valid || out_o.ready, "result load over a pending result")

endmodule
